// ===== design/bdll_pkg.sv =====
// Package for the bounded doubly linked list engine.
// Holds the request/result payload types, operation/status codes and FSM states.
`timescale 1ns / 1ps
`default_nettype none
package bdll_pkg;

	typedef enum logic [2:0] {
		OP_APPEND   = 3'd0,
		OP_POP_HEAD = 3'd1,
		OP_POP_TAIL = 3'd2,
		OP_REMOVE   = 3'd3,
		OP_LIST     = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] data_value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] item_value;
		logic               item_valid;
		logic               last_of_run;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_CHK,
		S_UNLINK,
		S_OUT,
		S_WAIT
	} state_t;

endpackage
`default_nettype wire

// ===== design/bdll_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bdll_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== design/bounded_doubly_linked_list.sv =====
// Top level of the bounded doubly linked list engine.
// Depends on bdll_pkg and bdll_ram (value, forward link, backward link memories).
//
// channel | dir | handshake        | payload
// req     | in  | req_valid/ready  | bdll_pkg::req_t (operation, data_value)
// rsp     | out | rsp_valid/ready  | bdll_pkg::rsp_t (status, item_value, item_valid, last_of_run)
//
// Append, full, empty and unused codes: the result is registered when the request is accepted.
// Head/tail removal passes through accept, memory read and check/unlink.
// Matching removal and listing walk the forward links, one memory read per entry.
// Reset clears head, tail, count and occupancy; memories need no clearing.
// A held result stalls the walk; a new request is taken once the previous one is done.
`timescale 1ns / 1ps
`default_nettype none
module bounded_doubly_linked_list #(
	parameter int CAPACITY   = 32,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire bdll_pkg::req_t   req,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output bdll_pkg::rsp_t        rsp
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	bdll_pkg::state_t state_q, state_d;

	logic [CAPACITY-1:0] used_q;
	logic [AW-1:0]       head_q, tail_q, cur_q, free_slot;
	logic [CW-1:0]       count_q, idx_q;
	logic [2:0]          op_q;
	logic [DATA_WIDTH-1:0] key_q;
	logic                found_free;

	logic                  v_we, f_we, b_we;
	logic [AW-1:0]         v_wa, f_wa, b_wa, rd_a;
	logic [DATA_WIDTH-1:0] v_wd, v_rd;
	logic [AW-1:0]         f_wd, b_wd, f_rd, b_rd;

	bdll_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_val (
		.clk, .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(rd_a), .rdata(v_rd));
	bdll_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_fwd (
		.clk, .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(rd_a), .rdata(f_rd));
	bdll_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_bwd (
		.clk, .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(rd_a), .rdata(b_rd));

	always_comb begin
		free_slot  = '0;
		found_free = 1'b0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_slot  = AW'(i);
				found_free = 1'b1;
			end
		end
	end

	logic signed [31:0] ext_val;
	assign ext_val = 32'(signed'(v_rd));

	logic is_walk, is_last, match;
	assign is_walk = (op_q == bdll_pkg::OP_REMOVE) || (op_q == bdll_pkg::OP_LIST);
	assign is_last = (idx_q + CW'(1) == count_q);
	assign match   = (v_rd == key_q);

	logic rsp_free;
	assign rsp_free  = !rsp_valid || rsp_ready;
	assign req_ready = (state_q == bdll_pkg::S_IDLE) && rsp_free;
	assign rd_a      = cur_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bdll_pkg::S_IDLE: if (req_valid && req_ready) begin
				if (req.operation == bdll_pkg::OP_APPEND ||
				    req.operation > bdll_pkg::OP_LIST || count_q == '0)
					state_d = bdll_pkg::S_IDLE;
				else state_d = bdll_pkg::S_RD;
			end
			bdll_pkg::S_RD:     state_d = bdll_pkg::S_CHK;
			bdll_pkg::S_CHK: begin
				if (!rsp_free) state_d = bdll_pkg::S_CHK;
				else if (op_q == bdll_pkg::OP_LIST)
					state_d = is_last ? bdll_pkg::S_IDLE : bdll_pkg::S_RD;
				else if (op_q == bdll_pkg::OP_REMOVE && !match)
					state_d = is_last ? bdll_pkg::S_IDLE : bdll_pkg::S_RD;
				else state_d = bdll_pkg::S_IDLE;
			end
			bdll_pkg::S_UNLINK: state_d = bdll_pkg::S_IDLE;
			bdll_pkg::S_OUT:    state_d = bdll_pkg::S_IDLE;
			bdll_pkg::S_WAIT:   state_d = bdll_pkg::S_IDLE;
			default:            state_d = bdll_pkg::S_IDLE;
		endcase
	end

	// memory writes: append in IDLE, unlink of a middle entry in CHK
	logic do_unlink;
	assign do_unlink = (state_q == bdll_pkg::S_CHK) && rsp_free &&
		((op_q == bdll_pkg::OP_POP_HEAD) || (op_q == bdll_pkg::OP_POP_TAIL) ||
		 (op_q == bdll_pkg::OP_REMOVE && match));
	logic mid;
	assign mid = (count_q != CW'(1)) && (cur_q != head_q) && (cur_q != tail_q);

	logic do_app;
	assign do_app = (state_q == bdll_pkg::S_IDLE) && req_valid && req_ready &&
		req.operation == bdll_pkg::OP_APPEND && count_q != CW'(CAPACITY) && found_free;

	always_comb begin
		v_we = do_app;
		v_wa = free_slot;
		v_wd = DATA_WIDTH'(req.data_value);
		f_we = 1'b0; f_wa = tail_q; f_wd = free_slot;
		b_we = 1'b0; b_wa = free_slot; b_wd = tail_q;
		if (do_app) begin
			b_we = 1'b1;
			f_we = (count_q != '0);
		end else if (do_unlink && mid) begin
			f_we = 1'b1; f_wa = b_rd; f_wd = f_rd;
			b_we = 1'b1; b_wa = f_rd; b_wd = b_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bdll_pkg::S_IDLE;
			used_q    <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			idx_q     <= '0;
			cur_q     <= '0;
			op_q      <= '0;
			rsp_valid <= 1'b0;
			rsp       <= '0;
		end else begin
			state_q <= state_d;
			if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
			if (state_q == bdll_pkg::S_IDLE && req_valid && req_ready) begin
				op_q      <= req.operation;
				idx_q     <= '0;
				cur_q     <= (req.operation == bdll_pkg::OP_POP_TAIL) ? tail_q : head_q;
				rsp_valid <= 1'b1;
				rsp.item_value  <= '0;
				rsp.item_valid  <= 1'b0;
				rsp.last_of_run <= 1'b1;
				rsp.status      <= bdll_pkg::ST_OK;
				if (req.operation == bdll_pkg::OP_APPEND) begin
					if (do_app) begin
						used_q[free_slot] <= 1'b1;
						count_q <= count_q + CW'(1);
						tail_q  <= free_slot;
						if (count_q == '0) head_q <= free_slot;
					end else rsp.status <= bdll_pkg::ST_FULL;
				end else if (req.operation <= bdll_pkg::OP_LIST) begin
					if (count_q == '0) rsp.status <= bdll_pkg::ST_EMPTY;
					else rsp_valid <= 1'b0;
				end
			end
			if (state_q == bdll_pkg::S_CHK && rsp_free) begin
				if (op_q == bdll_pkg::OP_LIST) begin
					rsp_valid       <= 1'b1;
					rsp.status      <= bdll_pkg::ST_OK;
					rsp.item_value  <= ext_val;
					rsp.item_valid  <= 1'b1;
					rsp.last_of_run <= is_last;
					idx_q <= idx_q + CW'(1);
					cur_q <= f_rd;
				end else if (do_unlink) begin
					rsp_valid       <= 1'b1;
					rsp.status      <= bdll_pkg::ST_OK;
					rsp.item_value  <= ext_val;
					rsp.item_valid  <= 1'b1;
					rsp.last_of_run <= 1'b1;
					used_q[cur_q]   <= 1'b0;
					count_q         <= count_q - CW'(1);
					if (count_q == CW'(1)) begin
						head_q <= '0;
						tail_q <= '0;
					end else if (cur_q == head_q) head_q <= f_rd;
					else if (cur_q == tail_q) tail_q <= b_rd;
				end else begin
					idx_q <= idx_q + CW'(1);
					cur_q <= f_rd;
					if (is_last) begin
						rsp_valid       <= 1'b1;
						rsp.status      <= bdll_pkg::ST_NOT_FOUND;
						rsp.item_value  <= '0;
						rsp.item_valid  <= 1'b0;
						rsp.last_of_run <= 1'b1;
					end
				end
			end
		end
	end

	logic [DATA_WIDTH-1:0] key_in;
	assign key_in = DATA_WIDTH'(req.data_value);
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) key_q <= key_in;
	end

	// walk states never run while the list is empty
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bdll_pkg::S_CHK) |-> (count_q != '0))
		else $error("walk on empty list");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == int'(count_q))
		else $error("occupancy and count disagree");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bdll_pkg::S_CHK && is_walk) |-> (idx_q < count_q))
		else $error("walk past end");
endmodule
`default_nettype wire

// ===== dv/tb_bounded_doubly_linked_list.sv =====
// Testbench for the bounded doubly linked list engine.
// Drives list requests, predicts results with a local list model, checks each result.
// Depends on bdll_pkg and bounded_doubly_linked_list.
`timescale 1ns / 1ps
module tb_bounded_doubly_linked_list;

	localparam int CAP = 32;
	localparam int MAX_CYCLES = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic rsp_ready = 1'b0;
	bdll_pkg::req_t req = '0;
	logic req_ready;
	logic rsp_valid;
	bdll_pkg::rsp_t rsp;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;
	int cycle_count = 0;

	// list contents in order, head at index 0
	logic signed [31:0] list_values[$];
	bdll_pkg::rsp_t expected_rsps[$];

	bounded_doubly_linked_list dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp);
		$display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, exp,
			cycle_count);
		error_count++;
	endtask

	function automatic bdll_pkg::rsp_t make_rsp(input logic [1:0] st,
			input logic signed [31:0] v, input logic iv, input logic last);
		bdll_pkg::rsp_t r;
		r.status = st;
		r.item_value = v;
		r.item_valid = iv;
		r.last_of_run = last;
		return r;
	endfunction

	task automatic predict_list_op(input bdll_pkg::req_t r);
		int i;
		int hit;
		hit = -1;
		case (r.operation)
			bdll_pkg::OP_APPEND: begin
				if (list_values.size() >= CAP) begin
					expected_rsps.push_back(make_rsp(bdll_pkg::ST_FULL, 0, 1'b0, 1'b1));
				end else begin
					list_values.push_back(r.data_value);
					expected_rsps.push_back(make_rsp(bdll_pkg::ST_OK, 0, 1'b0, 1'b1));
				end
			end
			bdll_pkg::OP_POP_HEAD, bdll_pkg::OP_POP_TAIL, bdll_pkg::OP_REMOVE,
			bdll_pkg::OP_LIST: begin
				if (list_values.size() == 0) begin
					expected_rsps.push_back(make_rsp(bdll_pkg::ST_EMPTY, 0, 1'b0, 1'b1));
				end else if (r.operation == bdll_pkg::OP_POP_HEAD) begin
					expected_rsps.push_back(make_rsp(bdll_pkg::ST_OK,
						list_values.pop_front(), 1'b1, 1'b1));
				end else if (r.operation == bdll_pkg::OP_POP_TAIL) begin
					expected_rsps.push_back(make_rsp(bdll_pkg::ST_OK,
						list_values.pop_back(), 1'b1, 1'b1));
				end else if (r.operation == bdll_pkg::OP_REMOVE) begin
					for (i = 0; i < list_values.size() && hit < 0; i++)
						if (list_values[i] == r.data_value)
							hit = i;
					if (hit < 0) begin
						expected_rsps.push_back(make_rsp(bdll_pkg::ST_NOT_FOUND, 0,
							1'b0, 1'b1));
					end else begin
						expected_rsps.push_back(make_rsp(bdll_pkg::ST_OK, list_values[hit],
							1'b1, 1'b1));
						list_values.delete(hit);
					end
				end else begin
					for (i = 0; i < list_values.size(); i++)
						expected_rsps.push_back(make_rsp(bdll_pkg::ST_OK, list_values[i],
							1'b1, i == list_values.size() - 1));
				end
			end
			default: expected_rsps.push_back(make_rsp(bdll_pkg::ST_OK, 0, 1'b0, 1'b1));
		endcase
	endtask

	// called at a falling edge; leaves valid high, the caller or an idle gap in the next call drops it
	task automatic send_request(input logic [2:0] op, input logic signed [31:0] value);
		bdll_pkg::req_t r;
		r.operation = op;
		r.data_value = value;
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(negedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		predict_list_op(r);
		@(negedge clk);
	endtask

	always @(negedge clk)
		rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsps.size() == 0) begin
				report_mismatch("unexpected result", rsp, 0);
			end else begin
				if (rsp.status != expected_rsps[0].status)
					report_mismatch("status", rsp.status, expected_rsps[0].status);
				if (rsp.item_value != expected_rsps[0].item_value)
					report_mismatch("item_value", rsp.item_value, expected_rsps[0].item_value);
				if (rsp.item_valid != expected_rsps[0].item_valid)
					report_mismatch("item_valid", rsp.item_valid, expected_rsps[0].item_valid);
				if (rsp.last_of_run != expected_rsps[0].last_of_run)
					report_mismatch("last_of_run", rsp.last_of_run,
						expected_rsps[0].last_of_run);
				void'(expected_rsps.pop_front());
			end
		end
	end

	function automatic logic signed [31:0] pick_value();
		int k;
		k = $urandom_range(9);
		if (k < 5)
			return $urandom_range(7);
		if (list_values.size() > 0 && k < 8)
			return list_values[$urandom_range(list_values.size() - 1)];
		return $urandom;
	endfunction

	task automatic test_directed_edges();
		send_request(bdll_pkg::OP_POP_HEAD, 0);
		send_request(bdll_pkg::OP_POP_TAIL, 0);
		send_request(bdll_pkg::OP_REMOVE, 5);
		send_request(bdll_pkg::OP_LIST, 0);
		send_request(3'd5, 0);
		send_request(3'd6, 32'h7fffffff);
		send_request(3'd7, -1);
		send_request(bdll_pkg::OP_APPEND, 32'h80000000);
		send_request(bdll_pkg::OP_APPEND, 32'h7fffffff);
		send_request(bdll_pkg::OP_APPEND, -1);
		send_request(bdll_pkg::OP_APPEND, 0);
		send_request(bdll_pkg::OP_LIST, 0);
		send_request(bdll_pkg::OP_REMOVE, 12345);
		send_request(bdll_pkg::OP_REMOVE, -1);
		send_request(bdll_pkg::OP_REMOVE, 32'h80000000);
		send_request(bdll_pkg::OP_POP_TAIL, 0);
		send_request(bdll_pkg::OP_POP_HEAD, 0);
		send_request(bdll_pkg::OP_LIST, 0);
	endtask

	task automatic test_fill_to_capacity();
		int i;
		for (i = 0; i < CAP; i++)
			send_request(bdll_pkg::OP_APPEND, i * 3 - 40);
		send_request(bdll_pkg::OP_APPEND, 99);
		send_request(bdll_pkg::OP_LIST, 0);
		send_request(bdll_pkg::OP_REMOVE, 5);
		send_request(bdll_pkg::OP_APPEND, 77);
		send_request(bdll_pkg::OP_REMOVE, -40);
		for (i = 0; i < CAP; i++)
			send_request(bdll_pkg::OP_POP_HEAD, 0);
	endtask

	task automatic test_random_ops(input int count, input int idle, input int stall);
		int i;
		int k;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (i = 0; i < count; i++) begin
			k = $urandom_range(99);
			if (k < 40)
				send_request(bdll_pkg::OP_APPEND, pick_value());
			else if (k < 52)
				send_request(bdll_pkg::OP_POP_HEAD, pick_value());
			else if (k < 64)
				send_request(bdll_pkg::OP_POP_TAIL, pick_value());
			else if (k < 84)
				send_request(bdll_pkg::OP_REMOVE, pick_value());
			else if (k < 95)
				send_request(bdll_pkg::OP_LIST, pick_value());
			else
				send_request(3'($urandom_range(7, 5)), $urandom);
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_edges();
		test_fill_to_capacity();
		test_random_ops(11, 0, 0);
		test_random_ops(11, 82, 0);
		test_random_ops(11, 0, 82);
		test_random_ops(11, 20, 20);
		req_valid <= 1'b0;
		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (error_count == 0 && expected_rsps.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
